>>> rtl/core/vmsf_pkg.sv
package vmsf_pkg;

    // datapath micro-operation codes
    typedef logic [4:0] t_op;

    localparam t_op OP_IDLE        = 5'd0;
    localparam t_op OP_SCAN_INIT   = 5'd1;
    localparam t_op OP_RD          = 5'd2;
    localparam t_op OP_SQ          = 5'd3;
    localparam t_op OP_ACC         = 5'd4;
    localparam t_op OP_LD_LEFT     = 5'd5;
    localparam t_op OP_LD_RIGHT    = 5'd6;
    localparam t_op OP_LD_WHOLE    = 5'd7;
    localparam t_op OP_DIV_STEP    = 5'd8;
    localparam t_op OP_MEAN        = 5'd9;
    localparam t_op OP_MUL0        = 5'd10;
    localparam t_op OP_MUL1        = 5'd11;
    localparam t_op OP_MUL2        = 5'd12;
    localparam t_op OP_DIV2_START  = 5'd13;
    localparam t_op OP_EVAL        = 5'd14;
    localparam t_op OP_NEXT        = 5'd15;
    localparam t_op OP_SAVE_W      = 5'd16;
    localparam t_op OP_WMUL0       = 5'd17;
    localparam t_op OP_WMUL1       = 5'd18;
    localparam t_op OP_WMUL2       = 5'd19;
    localparam t_op OP_RESULT      = 5'd20;
    localparam t_op OP_RESULT_NONE = 5'd21;

    // controller to datapath
    typedef struct packed {
        logic accept;
        t_op  op;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic elig;
        logic last_cut;
        logic few;
        logic best_valid;
    } t_status;

    // configuration register map
    localparam int REG_IDX_W = 1;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_MIN_SEGMENT     = 1'd0;
    localparam t_reg_idx REG_VARIANCE_FACTOR = 1'd1;

    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = 32;
    localparam int MIN_SEG_W  = 11;
    localparam int VFACT_W    = 16;
    localparam int VAR_W      = 64;
    localparam int VFACT_FRAC = 8;
    localparam logic [VFACT_W-1:0] VFACT_RESET = 16'd256;

endpackage

>>> rtl/core/vmsf_if.sv
// sample input channel
interface vmsf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic        last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

// result channel
interface vmsf_out_if #(parameter int IDX_W = 11);
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] split_index;

    modport source (output valid, output found, output split_index, input ready);
    modport sink (input valid, input found, input split_index, output ready);
endinterface

// configuration write channel
interface vmsf_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/vmsf_ram.sv
module vmsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/vmsf_ctrl.sv
module vmsf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  vmsf_pkg::t_status i_status,
    output vmsf_pkg::t_cmd   o_cmd
);

    localparam logic [4:0] ST_LOAD  = 5'd0;
    localparam logic [4:0] ST_FL1   = 5'd1;
    localparam logic [4:0] ST_FL2   = 5'd2;
    localparam logic [4:0] ST_INIT  = 5'd3;
    localparam logic [4:0] ST_RD    = 5'd4;
    localparam logic [4:0] ST_SQ    = 5'd5;
    localparam logic [4:0] ST_ACC   = 5'd6;
    localparam logic [4:0] ST_LDL   = 5'd7;
    localparam logic [4:0] ST_DIV1  = 5'd8;
    localparam logic [4:0] ST_MEAN  = 5'd9;
    localparam logic [4:0] ST_MUL0  = 5'd10;
    localparam logic [4:0] ST_MUL1  = 5'd11;
    localparam logic [4:0] ST_MUL2  = 5'd12;
    localparam logic [4:0] ST_SUB   = 5'd13;
    localparam logic [4:0] ST_DIV2  = 5'd14;
    localparam logic [4:0] ST_PDONE = 5'd15;
    localparam logic [4:0] ST_NEXT  = 5'd16;
    localparam logic [4:0] ST_FIN   = 5'd17;
    localparam logic [4:0] ST_WMUL0 = 5'd18;
    localparam logic [4:0] ST_WMUL1 = 5'd19;
    localparam logic [4:0] ST_WMUL2 = 5'd20;
    localparam logic [4:0] ST_CMP   = 5'd21;
    localparam logic [4:0] ST_OUT   = 5'd22;

    localparam logic [1:0] PART_L = 2'd0;
    localparam logic [1:0] PART_R = 2'd1;
    localparam logic [1:0] PART_W = 2'd2;

    logic [4:0]      r_state, n_state;
    logic [1:0]      r_part, n_part;
    vmsf_pkg::t_op   op;
    logic            accept;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_OUT);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd       = '{accept: accept, op: op};

    // sequencer over cuts and over the three variance parts
    always_comb begin
        n_state = r_state;
        n_part  = r_part;
        op      = vmsf_pkg::OP_IDLE;
        case (r_state)
            ST_LOAD: begin
                if (accept && i_in_last) n_state = ST_FL1;
            end
            ST_FL1: n_state = ST_FL2;
            ST_FL2: n_state = ST_INIT;
            ST_INIT: begin
                op      = vmsf_pkg::OP_SCAN_INIT;
                n_state = i_status.few ? ST_FIN : ST_RD;
            end
            ST_RD: begin
                op      = vmsf_pkg::OP_RD;
                n_state = ST_SQ;
            end
            ST_SQ: begin
                op      = vmsf_pkg::OP_SQ;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                op      = vmsf_pkg::OP_ACC;
                n_state = i_status.elig ? ST_LDL : ST_NEXT;
            end
            ST_LDL: begin
                op      = vmsf_pkg::OP_LD_LEFT;
                n_part  = PART_L;
                n_state = ST_DIV1;
            end
            ST_DIV1: begin
                op = vmsf_pkg::OP_DIV_STEP;
                if (i_status.div_done) n_state = ST_MEAN;
            end
            ST_MEAN: begin
                op      = vmsf_pkg::OP_MEAN;
                n_state = ST_MUL0;
            end
            ST_MUL0: begin
                op      = vmsf_pkg::OP_MUL0;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                op      = vmsf_pkg::OP_MUL1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                op      = vmsf_pkg::OP_MUL2;
                n_state = ST_SUB;
            end
            ST_SUB: begin
                op      = vmsf_pkg::OP_DIV2_START;
                n_state = ST_DIV2;
            end
            ST_DIV2: begin
                op = vmsf_pkg::OP_DIV_STEP;
                if (i_status.div_done) n_state = ST_PDONE;
            end
            ST_PDONE: begin
                case (r_part)
                    PART_L: begin
                        op      = vmsf_pkg::OP_LD_RIGHT;
                        n_part  = PART_R;
                        n_state = ST_DIV1;
                    end
                    PART_R: begin
                        op      = vmsf_pkg::OP_EVAL;
                        n_state = ST_NEXT;
                    end
                    default: begin
                        op      = vmsf_pkg::OP_SAVE_W;
                        n_state = ST_WMUL0;
                    end
                endcase
            end
            ST_NEXT: begin
                op      = vmsf_pkg::OP_NEXT;
                n_state = i_status.last_cut ? ST_FIN : ST_RD;
            end
            ST_FIN: begin
                if (i_status.best_valid) begin
                    op      = vmsf_pkg::OP_LD_WHOLE;
                    n_part  = PART_W;
                    n_state = ST_DIV1;
                end else begin
                    op      = vmsf_pkg::OP_RESULT_NONE;
                    n_state = ST_OUT;
                end
            end
            ST_WMUL0: begin
                op      = vmsf_pkg::OP_WMUL0;
                n_state = ST_WMUL1;
            end
            ST_WMUL1: begin
                op      = vmsf_pkg::OP_WMUL1;
                n_state = ST_WMUL2;
            end
            ST_WMUL2: begin
                op      = vmsf_pkg::OP_WMUL2;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                op      = vmsf_pkg::OP_RESULT;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_part  <= PART_L;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
        end
    end

endmodule

>>> rtl/core/vmsf_dp.sv
module vmsf_dp #(
    parameter int MAX_LEN = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vmsf_pkg::t_cmd                   i_cmd,
    output vmsf_pkg::t_status                o_status,
    input  logic [31:0]                      i_sample,
    input  logic                             i_cfg_valid,
    input  vmsf_pkg::t_reg_idx               i_cfg_index,
    input  logic [15:0]                      i_cfg_data,
    output logic                             o_found,
    output logic [$clog2(MAX_LEN+1)-1:0]     o_split_index
);

    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int AW  = $clog2(MAX_LEN);
    localparam int SW  = 32 + CW;
    localparam int DW  = 64 + CW;
    localparam int XW  = SW + 1;
    localparam int RW  = CW + 1;
    localparam int DCW = $clog2(DW + 1);
    localparam int EW  = ((CW > vmsf_pkg::MIN_SEG_W) ? CW : vmsf_pkg::MIN_SEG_W) + 1;
    localparam int RHW = vmsf_pkg::VAR_W + vmsf_pkg::VFACT_W;

    vmsf_pkg::t_op op;

    logic [CW-1:0]  r_count;
    logic [SW-1:0]  r_t1;
    logic [DW-1:0]  r_t2;
    logic           r_sq_v, r_prod_v;
    logic [31:0]    r_sq_x;
    logic [63:0]    r_prod;
    logic [CW-1:0]  r_cut;
    logic [SW-1:0]  r_l1;
    logic [DW-1:0]  r_l2;
    logic [CW-1:0]  r_c;
    logic [SW-1:0]  r_p1;
    logic [DW-1:0]  r_p2;
    logic [RW-1:0]  r_rem;
    logic [DW-1:0]  r_quo;
    logic [CW-1:0]  r_dvs;
    logic [DCW-1:0] r_dcnt;
    logic [31:0]    r_m;
    logic [XW-1:0]  r_x;
    logic [DW-1:0]  r_acc;
    logic [63:0]    r_var_l, r_best, r_whole;
    logic [CW-1:0]  r_best_cut;
    logic           r_best_v;
    logic [RHW-1:0] r_rhs;
    logic           r_found;
    logic [CW-1:0]  r_idx;
    logic [vmsf_pkg::MIN_SEG_W-1:0] r_ms;
    logic [vmsf_pkg::VFACT_W-1:0]   r_vf;

    logic           store;
    logic [31:0]    ram_q;
    logic [31:0]    mul_a, mul_b;
    logic [RW-1:0]  rem_sh, rem_nx;
    logic           ge;
    logic [63:0]    obj;
    logic           upd;
    logic           beat;
    logic           start;
    logic [DW-1:0]  start_dvd;
    logic [CW-1:0]  start_dvs;
    logic [EW-1:0]  e_i, e_m, e_n;

    assign op    = i_cmd.op;
    assign store = i_cmd.accept && (r_count < CW'(MAX_LEN));

    // sample store
    vmsf_ram #(.WIDTH(vmsf_pkg::SAMPLE_W), .DEPTH(MAX_LEN)) u_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_sample),
        .i_raddr (AW'(r_cut - CW'(1))),
        .o_rdata (ram_q)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = r_sq_x;
        mul_b = r_sq_x;
        case (op)
            vmsf_pkg::OP_SQ: begin
                mul_a = ram_q;
                mul_b = ram_q;
            end
            vmsf_pkg::OP_MUL0: begin
                mul_a = r_m;
                mul_b = r_x[31:0];
            end
            vmsf_pkg::OP_MUL1: begin
                mul_a = r_m;
                mul_b = 32'(r_x[XW-1:32]);
            end
            vmsf_pkg::OP_WMUL0: begin
                mul_a = r_whole[31:0];
                mul_b = 32'(r_vf);
            end
            vmsf_pkg::OP_WMUL1: begin
                mul_a = r_whole[63:32];
                mul_b = 32'(r_vf);
            end
            default: begin
                mul_a = r_sq_x;
                mul_b = r_sq_x;
            end
        endcase
    end

    // restoring divider step, one quotient bit a cycle
    assign rem_sh = {r_rem[RW-2:0], r_quo[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    // divider start source
    always_comb begin
        start     = 1'b1;
        start_dvd = DW'(r_l1);
        start_dvs = r_cut;
        case (op)
            vmsf_pkg::OP_LD_LEFT: begin
                start_dvd = DW'(r_l1);
                start_dvs = r_cut;
            end
            vmsf_pkg::OP_LD_RIGHT: begin
                start_dvd = DW'(r_t1 - r_l1);
                start_dvs = r_count - r_cut;
            end
            vmsf_pkg::OP_LD_WHOLE: begin
                start_dvd = DW'(r_t1);
                start_dvs = r_count;
            end
            vmsf_pkg::OP_DIV2_START: begin
                start_dvd = r_p2 - r_acc;
                start_dvs = r_c;
            end
            default: start = 1'b0;
        endcase
    end

    // objective of the current cut and best-cut update
    assign obj  = r_var_l + r_quo[63:0];
    assign upd  = (op == vmsf_pkg::OP_EVAL) && (!r_best_v || (obj < r_best));
    assign beat = {8'b0, r_best, {vmsf_pkg::VFACT_FRAC{1'b0}}} < r_rhs;

    // eligibility of the current cut
    assign e_i = EW'(r_cut);
    assign e_m = EW'(r_ms);
    assign e_n = EW'(r_count);

    assign o_status.div_done   = (r_dcnt == '0);
    assign o_status.elig       = (e_i > e_m) && ((e_m > e_n) || ((e_i + e_m) < e_n));
    assign o_status.last_cut   = ((e_i + EW'(1)) == e_n);
    assign o_status.few        = (r_count < CW'(2));
    assign o_status.best_valid = r_best_v;

    // control state and accumulators that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_t1     <= '0;
            r_t2     <= '0;
            r_sq_v   <= 1'b0;
            r_prod_v <= 1'b0;
            r_best_v <= 1'b0;
            r_dcnt   <= '0;
            r_ms     <= '0;
            r_vf     <= vmsf_pkg::VFACT_RESET;
        end else begin
            r_sq_v   <= store;
            r_prod_v <= r_sq_v;
            if (store) begin
                r_count <= r_count + CW'(1);
                r_t1    <= r_t1 + SW'(i_sample);
            end
            if (r_prod_v) r_t2 <= r_t2 + DW'(r_prod);
            if (start) begin
                r_dcnt <= DCW'(DW);
            end else if (op == vmsf_pkg::OP_DIV_STEP && r_dcnt != '0) begin
                r_dcnt <= r_dcnt - DCW'(1);
            end
            if (upd) r_best_v <= 1'b1;
            if (op == vmsf_pkg::OP_RESULT || op == vmsf_pkg::OP_RESULT_NONE) begin
                r_count  <= '0;
                r_t1     <= '0;
                r_t2     <= '0;
                r_best_v <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vmsf_pkg::REG_MIN_SEGMENT:
                        r_ms <= i_cfg_data[vmsf_pkg::MIN_SEG_W-1:0];
                    vmsf_pkg::REG_VARIANCE_FACTOR:
                        r_vf <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (store) r_sq_x <= i_sample;
        if (start) begin
            r_rem <= '0;
            r_quo <= start_dvd;
            r_dvs <= start_dvs;
        end else if (op == vmsf_pkg::OP_DIV_STEP && r_dcnt != '0) begin
            r_rem <= rem_nx;
            r_quo <= {r_quo[DW-2:0], ge};
        end
        if (upd) begin
            r_best     <= obj;
            r_best_cut <= r_cut;
        end
        case (op)
            vmsf_pkg::OP_SCAN_INIT: begin
                r_cut <= CW'(1);
                r_l1  <= '0;
                r_l2  <= '0;
            end
            vmsf_pkg::OP_SQ:   r_l1 <= r_l1 + SW'(ram_q);
            vmsf_pkg::OP_ACC:  r_l2 <= r_l2 + DW'(r_prod);
            vmsf_pkg::OP_NEXT: r_cut <= r_cut + CW'(1);
            vmsf_pkg::OP_LD_LEFT: begin
                r_c  <= r_cut;
                r_p1 <= r_l1;
                r_p2 <= r_l2;
            end
            vmsf_pkg::OP_LD_RIGHT: begin
                r_var_l <= r_quo[63:0];
                r_c     <= r_count - r_cut;
                r_p1    <= r_t1 - r_l1;
                r_p2    <= r_t2 - r_l2;
            end
            vmsf_pkg::OP_LD_WHOLE: begin
                r_c  <= r_count;
                r_p1 <= r_t1;
                r_p2 <= r_t2;
            end
            vmsf_pkg::OP_MEAN: begin
                r_m <= r_quo[31:0];
                r_x <= XW'(r_p1) + XW'(r_rem);
            end
            vmsf_pkg::OP_MUL1:  r_acc <= DW'(r_prod);
            vmsf_pkg::OP_MUL2:  r_acc <= r_acc + (DW'(r_prod) << 32);
            vmsf_pkg::OP_SAVE_W: r_whole <= r_quo[63:0];
            vmsf_pkg::OP_WMUL1: r_rhs <= RHW'(r_prod);
            vmsf_pkg::OP_WMUL2: r_rhs <= r_rhs + (RHW'(r_prod) << 32);
            vmsf_pkg::OP_RESULT: begin
                r_found <= beat;
                r_idx   <= beat ? r_best_cut : '0;
            end
            vmsf_pkg::OP_RESULT_NONE: begin
                r_found <= 1'b0;
                r_idx   <= '0;
            end
            default: ;
        endcase
    end

    assign o_found       = r_found;
    assign o_split_index = r_idx;

endmodule

>>> rtl/core/variance_min_split_finder.sv
// Minimum-variance split finder.
// Channels: i_in takes one unsigned Q16.16 sample per item with last marking the end of a
// sequence; o_out gives one item per sequence (found, split_index); i_cfg writes
// min_segment (index 0) and variance_factor (index 1, Q8.8) and is always ready.
// Loading takes one item per cycle. After the last item the block stops taking items and
// scans every cut after a setup step: per cut it reads, squares and accumulates one sample,
// and per eligible cut it works out two parts, each a mean division, a multiply and a
// variance division; then, when any cut was eligible, it works out the whole-sequence
// variance and the acceptance test. Each division is bit-serial over DW quotient bits, where
// DW = 64 + clog2(MAX_LEN+1) (75 for MAX_LEN = 1024). A one-sample sequence skips the
// scan. All divisions use the one shared bit-serial divider.
// The result sits in an output register until o_out.ready; no sample is taken while it
// waits, and a stalled receiver simply holds the block in that state. The next sequence
// may start the cycle after the result item is taken.
// Reset empties the sequence, clears the best cut and sets min_segment to 0 and
// variance_factor to 1.0; the sample memory is not cleared and needs no clearing pass.
// Samples beyond MAX_LEN in one sequence are dropped; the last mark still ends it.
module variance_min_split_finder #(
    parameter int MAX_LEN = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vmsf_in_if.sink           i_in,
    vmsf_out_if.source        o_out,
    vmsf_cfg_if.sink          i_cfg
);

    localparam int CW = $clog2(MAX_LEN + 1);

    vmsf_pkg::t_cmd    cmd;
    vmsf_pkg::t_status status;
    logic              in_ready;
    logic              out_valid;
    logic              found;
    logic [CW-1:0]     split_index;

    // controller
    vmsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath
    vmsf_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_sample      (i_in.sample),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_found       (found),
        .o_split_index (split_index)
    );

    // channel hookup
    assign i_in.ready        = in_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = out_valid;
    assign o_out.found       = found;
    assign o_out.split_index = split_index;

endmodule

>>> rtl/core/vmsf_checker.sv
module vmsf_checker #(
    parameter int IDX_W = 11
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_found,
    input logic [IDX_W-1:0] i_split_index
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // found goes with a nonzero cut, not found with cut zero
    a_found_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_found == (i_split_index != '0)))
        else $error("found and split_index disagree");

    // no item taken while a result waits
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("item taken while result pending");

    // a last item starts the scan and closes the input
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready && !i_out_valid)
        else $error("input still open after last item");

endmodule

bind variance_min_split_finder vmsf_checker #(.IDX_W($clog2(MAX_LEN + 1))) u_vmsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_last     (i_in.last),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_found       (o_out.found),
    .i_split_index (o_out.split_index)
);

>>> tb/tb_vmsf_pkg.sv
package tb_vmsf_pkg;

    // one sample item as queued for the driver
    typedef struct {
        logic [31:0] sample;
        logic        last;
    } t_sample_item;

    // one predicted split result
    typedef struct {
        logic        found;
        logic [10:0] split_index;
    } t_split_result;

endpackage

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 1024;
    localparam int STALL_LIMIT = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vmsf_in_if            in_ch ();
    vmsf_out_if #(.IDX_W(11)) out_ch ();
    vmsf_cfg_if           cfg_ch ();

    variance_min_split_finder #(.MAX_LEN(MAX_LEN)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    // stimulus and checking state
    tb_vmsf_pkg::t_sample_item  sample_q[$];
    tb_vmsf_pkg::t_split_result split_q[$];
    int            mismatch_cnt = 0;
    int            quiet_cycles = 0;
    bit            no_idle = 1'b0;
    bit            item_taken = 1'b0;

    // predictor copy of block state
    logic [31:0] seq_store [MAX_LEN];
    int          seq_len = 0;
    logic [10:0] min_seg_cfg = '0;
    logic [15:0] var_fact_cfg = vmsf_pkg::VFACT_RESET;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    // population variance of stored samples, Q32.32
    function automatic logic [63:0] seg_variance(input int from, input int cnt);
        logic [63:0]  sum;
        logic [63:0]  mean;
        logic [63:0]  dev;
        logic [127:0] sq_acc;
        logic [127:0] quo;
        sum = '0;
        sq_acc = '0;
        if (cnt == 0) return '0;
        for (int k = 0; k < cnt; k++) sum += {32'b0, seq_store[from + k]};
        mean = sum / cnt;
        for (int k = 0; k < cnt; k++) begin
            dev = ({32'b0, seq_store[from + k]} >= mean) ?
                  {32'b0, seq_store[from + k]} - mean : mean - {32'b0, seq_store[from + k]};
            sq_acc += {64'b0, dev * dev};
        end
        quo = sq_acc / cnt;
        return quo[63:0];
    endfunction

    // best cut over the stored sequence and its acceptance test
    function automatic tb_vmsf_pkg::t_split_result best_split();
        tb_vmsf_pkg::t_split_result res;
        logic [63:0]  best_obj;
        logic [63:0]  obj;
        logic [127:0] lhs;
        logic [127:0] rhs;
        int           best_at;
        bit           have_best;
        bit           ok;
        res.found = 1'b0;
        res.split_index = '0;
        have_best = 1'b0;
        best_obj = '1;
        best_at = 0;
        for (int i = 1; i < seq_len; i++) begin
            ok = (i > min_seg_cfg) && ((min_seg_cfg > seq_len) || (i + min_seg_cfg < seq_len));
            if (ok) begin
                obj = seg_variance(0, i) + seg_variance(i, seq_len - i);
                if (!have_best || obj < best_obj) begin
                    best_obj = obj;
                    best_at = i;
                    have_best = 1'b1;
                end
            end
        end
        if (have_best) begin
            lhs = {64'b0, best_obj} << 8;
            rhs = {64'b0, seg_variance(0, seq_len)} * {112'b0, var_fact_cfg};
            if (lhs < rhs) begin
                res.found = 1'b1;
                res.split_index = best_at[10:0];
            end
        end
        return res;
    endfunction

    // accepted sample item: store it and predict on the last one
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (seq_len < MAX_LEN) begin
                seq_store[seq_len] = in_ch.sample;
                seq_len++;
            end
            if (in_ch.last) begin
                split_q = {split_q, best_split()};
                seq_len = 0;
            end
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        tb_vmsf_pkg::t_sample_item nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || item_taken) begin
            if (sample_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 17)) begin
                nxt = sample_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.sample <= nxt.sample;
                in_ch.last <= nxt.last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver stalls
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && (no_idle || $urandom_range(0, 99) >= 17);
    end

    // result checker
    always @(posedge i_clk) begin
        tb_vmsf_pkg::t_split_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (split_q.size() == 0) begin
                report_mismatch("unexpected result", out_ch.split_index, 0);
            end else begin
                want = split_q.pop_front();
                if (out_ch.found !== want.found)
                    report_mismatch("found", out_ch.found, want.found);
                if (out_ch.split_index !== want.split_index)
                    report_mismatch("split_index", out_ch.split_index, want.split_index);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input vmsf_pkg::t_reg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == vmsf_pkg::REG_MIN_SEGMENT) min_seg_cfg = value[10:0];
        else var_fact_cfg = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input int min_seg, input int factor);
        write_reg(vmsf_pkg::REG_MIN_SEGMENT, min_seg[15:0]);
        write_reg(vmsf_pkg::REG_VARIANCE_FACTOR, factor[15:0]);
    endtask

    task automatic queue_seq(input logic [31:0] vals[$]);
        tb_vmsf_pkg::t_sample_item it;
        foreach (vals[k]) begin
            it.sample = vals[k];
            it.last = (k == vals.size() - 1);
            sample_q = {sample_q, it};
        end
    endtask

    // wait for all items out and all results back, then let the block settle
    task automatic drain();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || in_ch.valid || split_q.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    // random sequence: full range, two-level with noise, or tiny values
    task automatic queue_random_seq(output int len);
        logic [31:0] vals[$];
        logic [31:0] lo;
        logic [31:0] hi;
        int kind;
        int cut;
        len = $urandom_range(1, 12);
        kind = $urandom_range(0, 2);
        lo = $urandom;
        hi = $urandom;
        cut = $urandom_range(0, len);
        for (int k = 0; k < len; k++) begin
            case (kind)
                0: vals = {vals, 32'($urandom)};
                1: vals = {vals, ((k < cut) ? lo : hi) ^ 32'($urandom_range(0, 255))};
                default: vals = {vals, 32'($urandom_range(0, 15))};
            endcase
        end
        queue_seq(vals);
    endtask

    initial begin
        logic [31:0] vals[$];
        int len;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = vmsf_pkg::REG_MIN_SEGMENT;
        cfg_ch.data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single sample, extremes, clean step, constant and alternating sequences
        queue_seq('{32'hFFFF_FFFF});
        queue_seq('{32'h0, 32'hFFFF_FFFF});
        queue_seq('{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        queue_seq('{32'h5555_AAAA, 32'h5555_AAAA, 32'h5555_AAAA, 32'h5555_AAAA});
        queue_seq('{32'h1, 32'h2, 32'h1, 32'h2, 32'h1});
        drain();

        // no eligible cut, widest factor
        set_config(1024, 65535);
        queue_seq('{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h7});
        drain();

        // factor zero never accepts
        set_config(0, 0);
        queue_seq('{32'h10, 32'h10, 32'h9000_0000, 32'h9000_0000});
        drain();

        // longer sequence, narrow eligible window
        set_config(15, 256);
        vals.delete();
        for (int k = 0; k < 40; k++)
            vals = {vals, (k < 22) ? 32'h0001_0000 + 32'(k % 3) : 32'hF000_0000 - 32'(k % 5)};
        queue_seq(vals);
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: set_config($urandom_range(0, 4), $urandom_range(0, 65535));
                1: set_config(0, 65535);
                2: set_config($urandom_range(0, 2), 256);
                default: set_config($urandom_range(0, 6), $urandom_range(1, 1024));
            endcase
            no_idle = (ph == 5);
            for (int s = 0; s < 65; s += len) begin
                queue_random_seq(len);
            end
            drain();
        end
        no_idle = 1'b0;

        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
